### hw/rtl/ffsf_pkg.sv
package ffsf_pkg;

   localparam int TEMP_W  = 9;
   localparam int SMOKE_W = 14;
   localparam int CO_W    = 10;
   localparam int READ_W  = 15;
   localparam int GRADE_W = 17;
   localparam int SUM_W   = 18;
   localparam int RATE_W  = 10;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 80;

   typedef logic signed [READ_W-1:0] reading_type;
   typedef logic [GRADE_W-1:0]       grade_type;
   typedef logic [RATE_W-1:0]        rate_type;

   localparam grade_type LOW_GRADE = GRADE_W'(6553);
   localparam grade_type GRADE_ONE = GRADE_W'(65536);

   localparam int TEMP_X1  = 30;
   localparam int TEMP_X2  = 55;
   localparam int TEMP_X3  = 80;
   localparam int SMOKE_X1 = 300;
   localparam int SMOKE_X2 = 1000;
   localparam int SMOKE_X3 = 4000;
   localparam int CO_X1    = 30;
   localparam int CO_X2    = 100;
   localparam int CO_X3    = 200;

   // mean of three grades by reciprocal multiply
   localparam int              DIV3_SHIFT = 20;
   localparam int              DIV3_W     = 19;
   localparam logic [DIV3_W-1:0] DIV3_MULT = DIV3_W'(((1 << DIV3_SHIFT) + 2) / 3);

   localparam logic [RATE_W-1:0] RATE_SCALE = RATE_W'(1000);
   localparam int                RATE_SHIFT = 16;

endpackage

### hw/rtl/ffsf_grade.sv
module ffsf_grade #(
   parameter int X1 = 30,
   parameter int X2 = 55,
   parameter int X3 = 80
) (
   input  ffsf_pkg::reading_type reading,
   output ffsf_pkg::grade_type   grade
);
   import ffsf_pkg::*;

   localparam int M_W    = 13;
   localparam int MULT_W = 31;
   localparam int PROD_W = M_W + MULT_W;

   localparam int D1 = 10 * (X2 - X1);
   localparam int D2 = 2 * (X3 - X2);
   localparam int T1 = M_W + 16 + $clog2(D1);
   localparam int T2 = M_W + 16 + $clog2(D2);
   localparam longint unsigned MULT1 = ((64'd1 << T1) + 64'(D1) - 64'd1) / 64'(D1);
   localparam longint unsigned MULT2 = ((64'd1 << T2) + 64'(D2) - 64'd1) / 64'(D2);
   localparam logic [MULT_W-1:0] MULT1_C = MULT_W'(MULT1);
   localparam logic [MULT_W-1:0] MULT2_C = MULT_W'(MULT2);
   localparam int SH1 = T1 - 16;
   localparam int SH2 = T2 - 16;

   localparam reading_type X1_R = READ_W'(X1);
   localparam reading_type X2_R = READ_W'(X2);
   localparam reading_type X3_R = READ_W'(X3);
   localparam logic [15:0] W1_C = 16'(X2 - X1);
   localparam logic [15:0] W2_C = 16'(X3 - X2);

   logic [15:0]       diff1;
   logic [15:0]       diff2;
   logic [M_W-1:0]    m1;
   logic [M_W-1:0]    m2;
   logic [PROD_W-1:0] prod1;
   logic [PROD_W-1:0] prod2;
   grade_type         q1;
   grade_type         q2;

   assign diff1 = 16'(reading) - 16'(X1_R);
   assign diff2 = 16'(reading) - 16'(X2_R);
   assign m1    = M_W'(W1_C + {diff1[13:0], 2'b00});
   assign m2    = M_W'(W2_C + diff2);
   assign prod1 = PROD_W'(m1) * PROD_W'(MULT1_C);
   assign prod2 = PROD_W'(m2) * PROD_W'(MULT2_C);
   assign q1    = GRADE_W'(prod1 >> SH1);
   assign q2    = GRADE_W'(prod2 >> SH2);

   always_comb begin
      priority if (reading < X1_R) begin
         grade = LOW_GRADE;
      end else if (reading < X2_R) begin
         grade = q1;
      end else if (reading < X3_R) begin
         grade = q2;
      end else begin
         grade = GRADE_ONE;
      end
   end

endmodule

### hw/rtl/fuzzy_fire_sensor_fusion.sv
// fuzzy fire sensor fusion
// input stream req_*: one beat holds a temperature, a smoke and a co reading.
// each reading is graded by a four-segment piecewise-linear membership in
// q1.16, the three grades are averaged into a fire likelihood, and a sampling
// rate of likelihood times 1000 is derived from it.
// output stream rsp_*: exactly one beat per request beat, in order, carrying
// the three grades, the likelihood and the sampling rate.
// path: a taken request beat passes the input register, the grade multipliers,
// the mean-by-three multiplier and the rate multiplier into the output register
// before rsp_tvalid rises.
// throughput: one beat per cycle while rsp_tready is high; each of the four stages
// moves on whenever the stage after it is empty or moving.
// reset: all stages empty, rsp_tvalid low, req_tready high.
// stall: while rsp_tready is low the output beat holds; earlier stages keep
// filling until full, then req_tready drops.
module fuzzy_fire_sensor_fusion (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // temperature_c[8:0], smoke_ppm[22:9], co_ppm[32:23]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata   // temperature_grade[16:0], smoke_grade[33:17],
                                   // co_grade[50:34], fire_likelihood[67:51],
                                   // sample_rate[77:68]
);
   import ffsf_pkg::*;

   localparam int PROD3_W = SUM_W + DIV3_W;
   localparam int PRODR_W = GRADE_W + RATE_W;

   logic adv1, adv2, adv3, adv4;

   // stage 1: input register
   logic               s1_valid_ff, s1_valid_in;
   logic [TEMP_W-1:0]  temp_ff;
   logic [SMOKE_W-1:0] smoke_ff;
   logic [CO_W-1:0]    co_ff;

   // stage 2: grades
   logic      s2_valid_ff, s2_valid_in;
   grade_type s2_gt_ff, s2_gs_ff, s2_gc_ff;

   // stage 3: likelihood
   logic      s3_valid_ff, s3_valid_in;
   grade_type s3_gt_ff, s3_gs_ff, s3_gc_ff;
   grade_type lik_ff;

   // stage 4: output register
   logic      out_valid_ff, out_valid_in;
   grade_type out_gt_ff, out_gs_ff, out_gc_ff, out_lik_ff;
   rate_type  out_rate_ff;

   reading_type t_read, s_read, c_read;
   grade_type   gt, gs, gc;
   logic [SUM_W-1:0]   sum;
   logic [PROD3_W-1:0] prod3;
   grade_type          lik;
   logic [PRODR_W-1:0] prodr;
   rate_type           rate;

   assign adv4       = !out_valid_ff || rsp_tready;
   assign adv3       = !s3_valid_ff || adv4;
   assign adv2       = !s2_valid_ff || adv3;
   assign adv1       = !s1_valid_ff || adv2;
   assign req_tready = adv1;

   assign s1_valid_in  = adv1 ? req_tvalid  : s1_valid_ff;
   assign s2_valid_in  = adv2 ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in  = adv3 ? s2_valid_ff : s3_valid_ff;
   assign out_valid_in = adv4 ? s3_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         temp_ff  <= req_tdata[TEMP_W-1:0];
         smoke_ff <= req_tdata[TEMP_W +: SMOKE_W];
         co_ff    <= req_tdata[TEMP_W+SMOKE_W +: CO_W];
      end
   end

   assign t_read = reading_type'({{(READ_W-TEMP_W){temp_ff[TEMP_W-1]}}, temp_ff});
   assign s_read = reading_type'({{(READ_W-SMOKE_W){1'b0}}, smoke_ff});
   assign c_read = reading_type'({{(READ_W-CO_W){1'b0}}, co_ff});

   ffsf_grade #(.X1(TEMP_X1), .X2(TEMP_X2), .X3(TEMP_X3)) u_grade_temp (
      .reading (t_read),
      .grade   (gt)
   );

   ffsf_grade #(.X1(SMOKE_X1), .X2(SMOKE_X2), .X3(SMOKE_X3)) u_grade_smoke (
      .reading (s_read),
      .grade   (gs)
   );

   ffsf_grade #(.X1(CO_X1), .X2(CO_X2), .X3(CO_X3)) u_grade_co (
      .reading (c_read),
      .grade   (gc)
   );

   always_ff @(posedge clock) begin
      if (adv2) begin
         s2_gt_ff <= gt;
         s2_gs_ff <= gs;
         s2_gc_ff <= gc;
      end
   end

   assign sum   = SUM_W'(s2_gt_ff) + SUM_W'(s2_gs_ff) + SUM_W'(s2_gc_ff);
   assign prod3 = PROD3_W'(sum) * PROD3_W'(DIV3_MULT);
   assign lik   = GRADE_W'(prod3 >> DIV3_SHIFT);

   always_ff @(posedge clock) begin
      if (adv3) begin
         s3_gt_ff <= s2_gt_ff;
         s3_gs_ff <= s2_gs_ff;
         s3_gc_ff <= s2_gc_ff;
         lik_ff   <= lik;
      end
   end

   assign prodr = PRODR_W'(lik_ff) * PRODR_W'(RATE_SCALE);
   assign rate  = RATE_W'(prodr >> RATE_SHIFT);

   always_ff @(posedge clock) begin
      if (adv4) begin
         out_gt_ff   <= s3_gt_ff;
         out_gs_ff   <= s3_gs_ff;
         out_gc_ff   <= s3_gc_ff;
         out_lik_ff  <= lik_ff;
         out_rate_ff <= rate;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_rate_ff, out_lik_ff, out_gc_ff, out_gs_ff, out_gt_ff};

   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !s1_valid_ff && !s2_valid_ff && !s3_valid_ff)
      else $error("pipeline not empty after reset");

   a_grade_range : assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> s2_gt_ff >= LOW_GRADE && s2_gt_ff <= GRADE_ONE &&
                      s2_gs_ff >= LOW_GRADE && s2_gs_ff <= GRADE_ONE &&
                      s2_gc_ff >= LOW_GRADE && s2_gc_ff <= GRADE_ONE)
      else $error("grade out of range");

   a_lik_range : assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff |-> lik_ff >= LOW_GRADE && lik_ff <= GRADE_ONE)
      else $error("likelihood out of range");

   a_rate_range : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> out_rate_ff <= RATE_SCALE)
      else $error("sample rate out of range");

   a_stage3_hold : assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff && !adv3 |=> s3_valid_ff && $stable(lik_ff))
      else $error("stalled stage lost its beat");

endmodule
